### rtl/flash_record_log_store_macros.svh
// ---------------------------------------------------------------------------
// Record log store assertion macros
// Shorthand for clocked assertions with reset disable, used by the top level.
// ---------------------------------------------------------------------------
`ifndef FLASH_RECORD_LOG_STORE_MACROS_SVH
`define FLASH_RECORD_LOG_STORE_MACROS_SVH

// check a property at every clock edge outside reset
`define FRLS_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check that a condition is followed by another in the next cycle
`define FRLS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/frls_pkg.sv
// ---------------------------------------------------------------------------
// Record log store package
// Word format, request and result codes, result entry type.
// ---------------------------------------------------------------------------
package frls_pkg;

  localparam int WORD_W = 32;
  localparam int IDX_W  = 9;
  localparam int QDEPTH = 4;

  localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] HEADER_MASK = 32'h0000_00FF;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_SCAN   = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    RES_WRITTEN = 2'd0,
    RES_ERASED  = 2'd1,
    RES_SCAN    = 2'd2,
    RES_READ    = 2'd3
  } res_kind_e;

  typedef struct packed {
    res_kind_e         kind;
    logic [IDX_W-1:0]  index;
    logic [WORD_W-1:0] data;
    logic              found;
    logic [7:0]        last_rec;
    logic              last;
  } res_t;

endpackage

### rtl/frls_page_ram.sv
// ---------------------------------------------------------------------------
// Record log page memory
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module frls_page_ram #(
  parameter int Depth = 256,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [frls_pkg::WORD_W-1:0] wr_data_i,
  input  logic                       rd_en_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [frls_pkg::WORD_W-1:0] rd_data_o
);

  logic [frls_pkg::WORD_W-1:0] mem_q [Depth];
  logic [frls_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/flash_record_log_store.sv
// ---------------------------------------------------------------------------
// Record log store
// Append-only record log in one erasable page: byte packing, header scan,
// page erase and word read over a single-port-write page memory.
// ---------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  request  | in_valid_i / in_ready_o | kind, record_byte, record_length,
//           |                        | read_index
//  result   | out_valid_o/out_ready_i | result_kind, word_index, word_data,
//           |                        | scan_found, last_record_index, last_of_run
//
// Append: each byte is taken in ST_IDLE, which stays put unless an erase is due.
// Read: ST_READ pushes the word. Scan: ST_SCAN walks one header per step, each
// step waiting on the registered memory read. Erase: one word per cycle through
// the write port, then for a pending append or scan ST_FIN_A (and ST_FIN_B) issue results.
// Reset: a clearing pass over all LOG_WORDS words runs with in_ready_o low.
// Stalls: in_ready_o drops while the four-entry result queue has fewer than two free slots.
// ---------------------------------------------------------------------------
`include "flash_record_log_store_macros.svh"

module flash_record_log_store #(
  parameter int LOG_WORDS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  record_byte_i,
  input  logic [7:0]  record_length_i,
  input  logic [7:0]  read_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  result_kind_o,
  output logic [8:0]  word_index_o,
  output logic [31:0] word_data_o,
  output logic        scan_found_o,
  output logic [7:0]  last_record_index_o,
  output logic        last_of_run_o
);

  localparam int AW     = $clog2(LOG_WORDS);
  localparam int WpW    = AW + 1;
  localparam int SumW   = ((AW > 8) ? AW : 8) + 2;
  localparam int IdxW   = frls_pkg::IDX_W;
  localparam int WordW  = frls_pkg::WORD_W;
  localparam int QDepth = frls_pkg::QDEPTH;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;
  localparam logic [AW-1:0] SweepLast = AW'(LOG_WORDS - 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_ERASE = 6'b001000,
    ST_FIN_A = 6'b010000,
    ST_FIN_B = 6'b100000
  } state_e;

  typedef enum logic [1:0] {
    PEND_NONE   = 2'd0,
    PEND_APPEND = 2'd1,
    PEND_SCAN   = 2'd2
  } pend_e;

  state_e             state_q, state_d;
  pend_e              pend_q, pend_d;
  logic               pend_wr_q, pend_wr_d;
  logic [WordW-1:0]   pend_data_q, pend_data_d;
  logic [WpW-1:0]     wp_q, wp_d;
  logic               pv_q, pv_d;
  logic [7:0]         newest_q, newest_d;
  logic [WordW-1:0]   acc_q, acc_d;
  logic [7:0]         bp_q, bp_d;
  logic [AW-1:0]      sweep_q, sweep_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [7:0]         ridx_q, ridx_d;

  logic               mem_we, mem_re;
  logic [AW-1:0]      mem_wa, mem_ra;
  logic [WordW-1:0]   mem_wd, mem_rd;

  logic               push, pop;
  frls_pkg::res_t     push_res, head_res;
  frls_pkg::res_t     res_q [QDepth];
  logic [QPtrW-1:0]   head_q, tail_q;
  logic [QCntW-1:0]   cnt_q;

  logic               accept;
  logic [7:0]         len_eff;
  logic [8:0]         len_sum;
  logic [6:0]         words;
  logic [8:0]         bp_inc;
  logic               ap_end, ap_write, ap_fit_erase, ap_ovf_erase, ap_erase;
  logic [1:0]         lane;
  logic [WordW-1:0]   acc_base, ap_word;
  logic [7:0]         step;
  logic [SumW-1:0]    npos;
  logic               scan_full, read_oob;

  frls_page_ram #(
    .Depth (LOG_WORDS),
    .AddrW (AW)
  ) u_page_ram (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_wa),
    .wr_data_i (mem_wd),
    .rd_en_i   (mem_re),
    .rd_addr_i (mem_ra),
    .rd_data_o (mem_rd)
  );

  assign in_ready_o = (state_q == ST_IDLE) && (cnt_q <= QCntW'(QDepth - 2));
  assign accept     = in_valid_i && in_ready_o;

  // append datapath
  assign len_eff      = (record_length_i == 8'd0) ? 8'd1 : record_length_i;
  assign len_sum      = {1'b0, len_eff} + 9'd4;
  assign words        = len_sum[8:2];
  assign bp_inc       = {1'b0, bp_q} + 9'd1;
  assign ap_end       = bp_inc >= {1'b0, len_eff};
  assign lane         = bp_q[1:0] + 2'd1;
  assign acc_base     = (bp_q == 8'd0) ? WordW'(words) : acc_q;
  assign ap_word      = acc_base | (WordW'(record_byte_i) << {lane, 3'b000});
  assign ap_write     = (lane == 2'd3) || ap_end;
  assign ap_fit_erase = (bp_q == 8'd0) && pv_q &&
                        ((SumW'(wp_q) + SumW'(words)) > SumW'(LOG_WORDS));
  assign ap_ovf_erase = ap_write && (wp_q >= WpW'(LOG_WORDS));
  assign ap_erase     = ap_fit_erase || ap_ovf_erase;

  // scan and read datapath
  assign step      = 8'(mem_rd & frls_pkg::HEADER_MASK);
  assign npos      = SumW'(pos_q) + SumW'(step);
  assign scan_full = (step == 8'd0) || (npos >= SumW'(LOG_WORDS));
  assign read_oob  = SumW'(ridx_q) >= SumW'(LOG_WORDS);

  always_comb begin
    state_d     = state_q;
    pend_d      = pend_q;
    pend_wr_d   = pend_wr_q;
    pend_data_d = pend_data_q;
    wp_d        = wp_q;
    pv_d        = pv_q;
    newest_d    = newest_q;
    acc_d       = acc_q;
    bp_d        = bp_q;
    sweep_d     = sweep_q;
    pos_d       = pos_q;
    ridx_d      = ridx_q;
    mem_we      = 1'b0;
    mem_wa      = '0;
    mem_wd      = '0;
    mem_re      = 1'b0;
    mem_ra      = '0;
    push        = 1'b0;
    push_res    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            frls_pkg::KIND_APPEND: begin
              pv_d  = 1'b1;
              bp_d  = ap_end ? 8'd0 : bp_inc[7:0];
              acc_d = (ap_end || ap_write) ? '0 : ap_word;
              if (ap_erase) begin
                pend_d      = PEND_APPEND;
                pend_wr_d   = ap_write;
                pend_data_d = ap_word;
                sweep_d     = '0;
                state_d     = ST_ERASE;
              end else if (ap_write) begin
                mem_we         = 1'b1;
                mem_wa         = AW'(wp_q);
                mem_wd         = ap_word;
                wp_d           = wp_q + WpW'(1);
                push           = 1'b1;
                push_res.kind  = frls_pkg::RES_WRITTEN;
                push_res.index = IdxW'(wp_q);
                push_res.data  = ap_word;
                push_res.last  = 1'b1;
              end
            end
            frls_pkg::KIND_SCAN: begin
              bp_d    = 8'd0;
              acc_d   = '0;
              pos_d   = '0;
              mem_re  = 1'b1;
              mem_ra  = '0;
              state_d = ST_SCAN;
            end
            frls_pkg::KIND_READ: begin
              ridx_d  = read_index_i;
              mem_re  = 1'b1;
              mem_ra  = AW'(read_index_i);
              state_d = ST_READ;
            end
            default: begin
              // drop unknown request
            end
          endcase
        end
      end
      ST_READ: begin
        push           = 1'b1;
        push_res.kind  = frls_pkg::RES_READ;
        push_res.index = IdxW'(ridx_q);
        push_res.data  = read_oob ? frls_pkg::ERASED_WORD : mem_rd;
        push_res.last  = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_SCAN: begin
        if (mem_rd == frls_pkg::ERASED_WORD) begin
          wp_d              = WpW'(pos_q);
          pv_d              = 1'b1;
          push              = 1'b1;
          push_res.kind     = frls_pkg::RES_SCAN;
          push_res.index    = IdxW'(pos_q);
          push_res.found    = 1'b1;
          push_res.last_rec = newest_q;
          push_res.last     = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          newest_d = 8'(pos_q);
          if (scan_full) begin
            pend_d  = PEND_SCAN;
            sweep_d = '0;
            state_d = ST_ERASE;
          end else begin
            pos_d  = AW'(npos);
            mem_re = 1'b1;
            mem_ra = AW'(npos);
          end
        end
      end
      ST_ERASE: begin
        mem_we  = 1'b1;
        mem_wa  = sweep_q;
        mem_wd  = frls_pkg::ERASED_WORD;
        sweep_d = sweep_q + AW'(1);
        if (sweep_q == SweepLast) begin
          wp_d = '0;
          if (pend_q == PEND_NONE) begin
            state_d = ST_IDLE;
          end else begin
            pv_d    = 1'b1;
            state_d = ST_FIN_A;
          end
        end
      end
      ST_FIN_A: begin
        push           = 1'b1;
        push_res.kind  = frls_pkg::RES_ERASED;
        push_res.data  = frls_pkg::ERASED_WORD;
        push_res.last  = !((pend_q == PEND_SCAN) || pend_wr_q);
        if ((pend_q == PEND_APPEND) && pend_wr_q) begin
          mem_we = 1'b1;
          mem_wa = '0;
          mem_wd = pend_data_q;
          wp_d   = WpW'(1);
        end
        state_d = push_res.last ? ST_IDLE : ST_FIN_B;
      end
      ST_FIN_B: begin
        push          = 1'b1;
        push_res.last = 1'b1;
        if (pend_q == PEND_SCAN) begin
          push_res.kind     = frls_pkg::RES_SCAN;
          push_res.last_rec = newest_q;
        end else begin
          push_res.kind = frls_pkg::RES_WRITTEN;
          push_res.data = pend_data_q;
        end
        pend_d  = PEND_NONE;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_ERASE;
      pend_q    <= PEND_NONE;
      pend_wr_q <= 1'b0;
      wp_q      <= '0;
      pv_q      <= 1'b0;
      newest_q  <= '0;
      acc_q     <= '0;
      bp_q      <= '0;
      sweep_q   <= '0;
      pos_q     <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      pend_wr_q <= pend_wr_d;
      wp_q      <= wp_d;
      pv_q      <= pv_d;
      newest_q  <= newest_d;
      acc_q     <= acc_d;
      bp_q      <= bp_d;
      sweep_q   <= sweep_d;
      pos_q     <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_data_q <= pend_data_d;
    ridx_q      <= ridx_d;
  end

  // result queue
  assign pop = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      res_q[tail_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        tail_q <= tail_q + QPtrW'(1);
      end
      if (pop) begin
        head_q <= head_q + QPtrW'(1);
      end
      cnt_q <= cnt_q + QCntW'(push) - QCntW'(pop);
    end
  end

  assign head_res            = res_q[head_q];
  assign out_valid_o         = cnt_q != '0;
  assign result_kind_o       = head_res.kind;
  assign word_index_o        = head_res.index;
  assign word_data_o         = head_res.data;
  assign scan_found_o        = head_res.found;
  assign last_record_index_o = head_res.last_rec;
  assign last_of_run_o       = head_res.last;

  `FRLS_ASSERT(a_queue_room, push |-> ((cnt_q < QCntW'(QDepth)) || pop), "result queue overflow")
  `FRLS_ASSERT(a_wp_in_page, wp_q <= WpW'(LOG_WORDS), "write pointer beyond page end")
  `FRLS_ASSERT(a_scan_no_write, (state_q == ST_SCAN) |-> !mem_we, "page write during scan walk")
  `FRLS_ASSERT_NEXT(a_erase_done, (state_q == ST_ERASE) && (sweep_q == SweepLast) && (pend_q != PEND_NONE), (state_q == ST_FIN_A) && (wp_q == '0), "erase did not hand over to result issue")

endmodule

### dv/frls_check_pkg.sv
// ---------------------------------------------------------------------------
// Record log store checking package
// Mirror of the log page that predicts the results of every accepted request
// and compares them, in order, with the results the block returns.
// ---------------------------------------------------------------------------
package frls_check_pkg;

  localparam int LOG_WORDS = 256;

  class log_page_scoreboard;

    logic [frls_pkg::WORD_W-1:0] page_mirror [LOG_WORDS];
    logic [8:0]                  free_ptr;
    bit                          ptr_known;
    logic [7:0]                  newest_hdr;
    logic [frls_pkg::WORD_W-1:0] word_acc;
    logic [7:0]                  bytes_taken;

    frls_pkg::res_t due_results [$];
    int unsigned    failures;
    int unsigned    checked;
    int unsigned    erases;
    int unsigned    scans;
    int unsigned    full_scans;

    function new();
      foreach (page_mirror[i]) page_mirror[i] = frls_pkg::ERASED_WORD;
      free_ptr    = '0;
      ptr_known   = 1'b0;
      newest_hdr  = '0;
      word_acc    = '0;
      bytes_taken = '0;
      failures    = 0;
      checked     = 0;
      erases      = 0;
      scans       = 0;
      full_scans  = 0;
    endfunction

    function void push(frls_pkg::res_kind_e k, logic [8:0] idx,
                       logic [frls_pkg::WORD_W-1:0] d, logic f, logic [7:0] lr);
      frls_pkg::res_t entry;
      entry = '{kind: k, index: idx, data: d, found: f, last_rec: lr, last: 1'b0};
      due_results.push_back(entry);
    endfunction

    function void wipe_page();
      foreach (page_mirror[i]) page_mirror[i] = frls_pkg::ERASED_WORD;
      free_ptr  = '0;
      ptr_known = 1'b1;
      erases++;
      push(frls_pkg::RES_ERASED, '0, frls_pkg::ERASED_WORD, 1'b0, '0);
    endfunction

    function void note_request(logic [1:0] kind, logic [7:0] byte_v, logic [7:0] len_v,
                               logic [7:0] ridx);
      int unsigned base;
      int unsigned len;
      int unsigned words;
      int unsigned pos;
      logic [1:0]  lane;
      logic [frls_pkg::WORD_W-1:0] hdr_word;
      bit          full;
      frls_pkg::res_t tail;
      base = due_results.size();
      case (kind)
        frls_pkg::KIND_APPEND: begin
          len = (len_v == 0) ? 1 : len_v;
          if (bytes_taken == 0) begin
            words = (len + 4) / 4;
            if (!ptr_known) begin
              free_ptr  = '0;
              ptr_known = 1'b1;
            end else if (free_ptr + words > LOG_WORDS) begin
              wipe_page();
            end
            word_acc = words;
          end
          lane = bytes_taken[1:0] + 2'd1;
          word_acc = word_acc | (32'(byte_v) << {lane, 3'b000});
          if (lane == 2'd3 || bytes_taken + 1 >= len) begin
            if (free_ptr >= LOG_WORDS) wipe_page();
            page_mirror[free_ptr] = word_acc;
            push(frls_pkg::RES_WRITTEN, free_ptr, word_acc, 1'b0, '0);
            free_ptr = free_ptr + 9'd1;
            word_acc = '0;
          end
          bytes_taken = bytes_taken + 8'd1;
          if (bytes_taken >= len) begin
            bytes_taken = '0;
            word_acc    = '0;
          end
        end
        frls_pkg::KIND_SCAN: begin
          scans++;
          pos      = 0;
          hdr_word = page_mirror[0];
          full     = 1'b0;
          bytes_taken = '0;
          word_acc    = '0;
          if (hdr_word != frls_pkg::ERASED_WORD) begin
            while (pos < LOG_WORDS && hdr_word != frls_pkg::ERASED_WORD) begin
              newest_hdr = 8'(pos);
              if ((hdr_word & frls_pkg::HEADER_MASK) == 0) begin
                full = 1'b1;
                break;
              end
              pos = pos + hdr_word[7:0];
              if (pos < LOG_WORDS) hdr_word = page_mirror[pos];
            end
            if (pos >= LOG_WORDS) full = 1'b1;
          end
          if (full) begin
            full_scans++;
            wipe_page();
            push(frls_pkg::RES_SCAN, '0, '0, 1'b0, newest_hdr);
          end else begin
            free_ptr  = 9'(pos);
            ptr_known = 1'b1;
            push(frls_pkg::RES_SCAN, 9'(pos), '0, 1'b1, newest_hdr);
          end
        end
        frls_pkg::KIND_READ:
          push(frls_pkg::RES_READ, {1'b0, ridx}, page_mirror[ridx], 1'b0, '0);
        default: ;
      endcase
      if (due_results.size() > base) begin
        tail = due_results.pop_back();
        tail.last = 1'b1;
        due_results.push_back(tail);
      end
    endfunction

    function void check_result(frls_pkg::res_t got);
      frls_pkg::res_t want;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: kind %0d index %0d data %h found %0b last_rec %0d last %0b",
                   got.kind, got.index, got.data, got.found, got.last_rec, got.last);
        return;
      end
      want = due_results.pop_front();
      checked++;
      if (got.kind !== want.kind || got.index !== want.index || got.data !== want.data ||
          got.found !== want.found || got.last_rec !== want.last_rec ||
          got.last !== want.last) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch on result %0d:", checked);
          $display("  expected kind %0d index %0d data %h found %0b last_rec %0d last %0b",
                   want.kind, want.index, want.data, want.found, want.last_rec, want.last);
          $display("  actual   kind %0d index %0d data %h found %0b last_rec %0d last %0b",
                   got.kind, got.index, got.data, got.found, got.last_rec, got.last);
        end
      end
    endfunction

  endclass

endpackage

### dv/tb.sv
// ---------------------------------------------------------------------------
// Record log store testbench
// Directed and random requests (appends, scans, reads, ignored codes) with
// random idling on both channels; every result is checked against a page
// mirror in the order it arrives.
// ---------------------------------------------------------------------------
module tb;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned TOTAL_REQUESTS = 1550;
  localparam int LOG_WORDS = frls_check_pkg::LOG_WORDS;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  kind_i;
  logic [7:0]  record_byte_i;
  logic [7:0]  record_length_i;
  logic [7:0]  read_index_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  result_kind_o;
  logic [8:0]  word_index_o;
  logic [31:0] word_data_o;
  logic        scan_found_o;
  logic [7:0]  last_record_index_o;
  logic        last_of_run_o;

  frls_check_pkg::log_page_scoreboard board;
  int unsigned requests_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  flash_record_log_store #(
    .LOG_WORDS(LOG_WORDS)
  ) dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .kind_i             (kind_i),
    .record_byte_i      (record_byte_i),
    .record_length_i    (record_length_i),
    .read_index_i       (read_index_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .word_index_o       (word_index_o),
    .word_data_o        (word_data_o),
    .scan_found_o       (scan_found_o),
    .last_record_index_o(last_record_index_o),
    .last_of_run_o      (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAIL flash_record_log_store");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        board.note_request(kind_i, record_byte_i, record_length_i, read_index_i);
      if (out_valid_o && out_ready_i)
        board.check_result(frls_pkg::res_t'({result_kind_o, word_index_o, word_data_o,
                                             scan_found_o, last_record_index_o,
                                             last_of_run_o}));
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(logic [1:0] kind, logic [7:0] byte_v, logic [7:0] len_v,
                              logic [7:0] ridx);
    if (requests_sent < TOTAL_REQUESTS / 3) begin
      send_idle_pct = 38;
      recv_idle_pct = 56;
    end else if (requests_sent < 2 * TOTAL_REQUESTS / 3) begin
      send_idle_pct = 56;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      = 1'b1;
    kind_i          = kind;
    record_byte_i   = byte_v;
    record_length_i = len_v;
    read_index_i    = ridx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (kind != KIND_UNUSED) requests_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 8'($urandom_range(1, 8));
    if (r < 92) return 8'($urandom_range(9, 40));
    if (r < 98) return 8'($urandom_range(41, 255));
    return ($urandom_range(1) == 1) ? 8'd255 : 8'd0;
  endfunction

  task automatic append_record(logic [7:0] len);
    int unsigned n;
    n = (len == 0) ? 1 : len;
    repeat (n) send_request(frls_pkg::KIND_APPEND, 8'($urandom), len, 8'($urandom));
  endtask

  // change the length within a record: truncated, overlong or left unfinished
  task automatic append_broken();
    int unsigned n;
    logic [7:0]  len;
    n   = $urandom_range(1, 40);
    len = pick_length();
    repeat (n) begin
      if ($urandom_range(3) == 0)
        len = ($urandom_range(1) == 1) ? 8'd255 : pick_length();
      send_request(frls_pkg::KIND_APPEND, 8'($urandom), len, 8'($urandom));
    end
  endtask

  initial begin
    int unsigned pick;
    board           = new();
    requests_sent   = 0;
    send_idle_pct   = 38;
    recv_idle_pct   = 56;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    kind_i          = frls_pkg::KIND_APPEND;
    record_byte_i   = '0;
    record_length_i = 8'd1;
    read_index_i    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(frls_pkg::KIND_SCAN, 8'h00, 8'h01, 8'h00);
    send_request(frls_pkg::KIND_READ, 8'h00, 8'h01, 8'h00);
    send_request(frls_pkg::KIND_READ, 8'hFF, 8'hFF, 8'hFF);
    send_request(frls_pkg::KIND_APPEND, 8'h00, 8'd1, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'hFF, 8'd0, 8'hFF);
    send_request(frls_pkg::KIND_APPEND, 8'hFF, 8'd3, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h5A, 8'd3, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'hA5, 8'd3, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h80, 8'd4, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h01, 8'd4, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h7F, 8'd4, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'hFE, 8'd4, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h11, 8'd200, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h22, 8'd2, 8'h00);
    send_request(KIND_UNUSED, 8'hFF, 8'hFF, 8'hFF);
    send_request(frls_pkg::KIND_READ, 8'h00, 8'h01, 8'd1);
    send_request(frls_pkg::KIND_READ, 8'h00, 8'h01, 8'd4);
    send_request(frls_pkg::KIND_READ, 8'h00, 8'h01, 8'd128);
    send_request(frls_pkg::KIND_SCAN, 8'h00, 8'h01, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h33, 8'd5, 8'h00);
    send_request(frls_pkg::KIND_APPEND, 8'h44, 8'd5, 8'h00);
    send_request(frls_pkg::KIND_SCAN, 8'h00, 8'h01, 8'h00);
    send_request(frls_pkg::KIND_READ, 8'h00, 8'h01, 8'd5);

    while (requests_sent < TOTAL_REQUESTS) begin
      pick = $urandom_range(99);
      if (pick < 62)
        append_record(pick_length());
      else if (pick < 72)
        append_broken();
      else if (pick < 82)
        send_request(frls_pkg::KIND_SCAN, 8'($urandom), 8'($urandom), 8'($urandom));
      else if (pick < 97)
        send_request(frls_pkg::KIND_READ, 8'($urandom), 8'($urandom),
                     ($urandom_range(1) == 1) ? 8'($urandom) : 8'($urandom_range(0, 31)));
      else
        send_request(KIND_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    in_valid_i = 1'b0;

    // drain, then allow for an erase still in flight
    while (board.due_results.size() != 0) @(posedge clk_i);
    repeat (2 * LOG_WORDS) @(posedge clk_i);

    $display("Covered %0d requests over three idling phases; %0d results checked.",
             requests_sent, board.checked);
    $display("Page erases: %0d; scans: %0d, of which %0d met a full page.",
             board.erases, board.scans, board.full_scans);
    if (board.failures == 0 && board.due_results.size() == 0)
      $display("PASS flash_record_log_store");
    else
      $display("FAIL flash_record_log_store");
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/frls_pkg.sv
rtl/frls_page_ram.sv
rtl/flash_record_log_store.sv
dv/frls_check_pkg.sv
dv/tb.sv
